// ===== rtl/lxdc_pkg.sv =====
// Package for the keystream decryptor with running CRC-16.
// Holds the register map, reset values, configuration struct and the CRC fold function.
// No dependencies.
`timescale 1ns / 1ps

package lxdc_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] REG_KEY_SEED       = 2'd0;
    localparam logic [1:0] REG_KEY_MULTIPLIER = 2'd1;
    localparam logic [1:0] REG_KEY_INCREMENT  = 2'd2;
    localparam logic [1:0] REG_EXPECTED_CRC   = 2'd3;

    localparam logic [WORD_W-1:0] RST_KEY_SEED       = 16'd0;
    localparam logic [WORD_W-1:0] RST_KEY_MULTIPLIER = 16'd25173;
    localparam logic [WORD_W-1:0] RST_KEY_INCREMENT  = 16'd13849;
    localparam logic [WORD_W-1:0] RST_EXPECTED_CRC   = 16'd0;

    localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [WORD_W-1:0] KEY_INIT = 16'h0000;

    typedef struct packed {
        logic [WORD_W-1:0] key_seed;
        logic [WORD_W-1:0] key_multiplier;
        logic [WORD_W-1:0] key_increment;
        logic [WORD_W-1:0] expected_crc;
    } t_cfg;

    function automatic logic [WORD_W-1:0] crc_fold8(
        input logic [WORD_W-1:0] crc,
        input logic [WORD_W-1:0] word
    );
        logic [WORD_W-1:0] c;
        c = crc ^ word;
        for (int n = 0; n < 8; n++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/lxdc_regs.sv =====
// APB-style configuration register file for the keystream decryptor.
// Depends on lxdc_pkg for the register map and reset values.
`timescale 1ns / 1ps

module lxdc_regs
    import lxdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg              r_cfg;
    logic              w_wr;
    logic [1:0]        w_idx;
    logic [WORD_W-1:0] w_rd;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_seed       <= RST_KEY_SEED;
            r_cfg.key_multiplier <= RST_KEY_MULTIPLIER;
            r_cfg.key_increment  <= RST_KEY_INCREMENT;
            r_cfg.expected_crc   <= RST_EXPECTED_CRC;
        end else if (w_wr) begin
            case (w_idx)
                REG_KEY_SEED:       r_cfg.key_seed       <= pwdata[WORD_W-1:0];
                REG_KEY_MULTIPLIER: r_cfg.key_multiplier <= pwdata[WORD_W-1:0];
                REG_KEY_INCREMENT:  r_cfg.key_increment  <= pwdata[WORD_W-1:0];
                REG_EXPECTED_CRC:   r_cfg.expected_crc   <= pwdata[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_KEY_SEED:       w_rd = r_cfg.key_seed;
            REG_KEY_MULTIPLIER: w_rd = r_cfg.key_multiplier;
            REG_KEY_INCREMENT:  w_rd = r_cfg.key_increment;
            REG_EXPECTED_CRC:   w_rd = r_cfg.expected_crc;
            default:            w_rd = '0;
        endcase
    end

    assign prdata = {{(DATA_W-WORD_W){1'b0}}, w_rd};
    assign o_cfg  = r_cfg;

endmodule

// ===== rtl/lxdc_core.sv =====
// Keystream and CRC state with the combinational decrypt and CRC fold logic.
// Depends on lxdc_pkg for the configuration struct and the CRC fold function.
`timescale 1ns / 1ps

module lxdc_core
    import lxdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_advance,
    input  logic [WORD_W-1:0] i_cipher_word,
    input  logic              i_first_word,
    input  logic              i_last_word,
    output logic [WORD_W-1:0] o_plain_word,
    output logic [WORD_W-1:0] o_running_crc,
    output logic              o_crc_match
);

    logic [WORD_W-1:0]   r_key;
    logic [WORD_W-1:0]   r_crc;
    logic [WORD_W-1:0]   n_key;
    logic [WORD_W-1:0]   n_crc;
    logic [WORD_W-1:0]   w_key_base;
    logic [WORD_W-1:0]   w_crc_base;
    logic [WORD_W-1:0]   w_prod;

    assign w_key_base = i_first_word ? i_cfg.key_seed : r_key;
    assign w_crc_base = i_first_word ? CRC_INIT : r_crc;
    assign w_prod     = w_key_base * i_cfg.key_multiplier;
    assign n_key      = w_prod + i_cfg.key_increment;
    assign o_plain_word = i_cipher_word ^ n_key;
    assign n_crc      = crc_fold8(w_crc_base, o_plain_word);
    assign o_running_crc = n_crc;
    assign o_crc_match = i_last_word & (n_crc == i_cfg.expected_crc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_INIT;
            r_crc <= CRC_INIT;
        end else if (i_advance) begin
            r_key <= n_key;
            r_crc <= n_crc;
        end
    end

endmodule

// ===== rtl/lcg_xor_decrypt_with_crc16_top.sv =====
// Top level of the keystream decryptor with running CRC-16.
// Depends on lxdc_pkg, lxdc_regs and lxdc_core.
//
// Usage: each input transaction carries one encrypted 16-bit word with its
// first and last marks. The block advances a 16-bit linear congruential
// keystream, XORs it into the word, folds the plain word into a CRC-16
// and returns one output transaction per input transaction.
// A word is captured in the input register, then decrypted and folded into
// the CRC on its way into the output register. Throughput is one word per
// cycle while the receiver does not stall; the keystream multiply-add and the
// eight CRC shift steps between the two registers set the clock period.
// When the receiver stalls, the output register holds its result and the
// input register takes a word only while empty. Reset clears both registers'
// valid flags, loads the keystream with zero, the CRC with 0xFFFF and the
// configuration registers with their defaults. The user must write the
// configuration through the APB port while idle; the block does not enforce it.
`timescale 1ns / 1ps

module lcg_xor_decrypt_with_crc16_top
    import lxdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [WORD_W-1:0] i_cipher_word,
    input  logic              i_first_word,
    input  logic              i_last_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_plain_word,
    output logic [WORD_W-1:0] o_running_crc,
    output logic              o_crc_match,
    output logic              o_end_of_image
);

    t_cfg              w_cfg;
    logic              r_s1_valid;
    logic [WORD_W-1:0] r_s1_cipher;
    logic              r_s1_first;
    logic              r_s1_last;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_plain;
    logic [WORD_W-1:0] r_out_crc;
    logic              r_out_match;
    logic              r_out_last;
    logic              w_advance;
    logic              w_in_take;
    logic [WORD_W-1:0] w_plain;
    logic [WORD_W-1:0] w_crc;
    logic              w_match;

    lxdc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lxdc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_advance     (w_advance),
        .i_cipher_word (r_s1_cipher),
        .i_first_word  (r_s1_first),
        .i_last_word   (r_s1_last),
        .o_plain_word  (w_plain),
        .o_running_crc (w_crc),
        .o_crc_match   (w_match)
    );

    assign w_advance  = r_s1_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_s1_valid | w_advance;
    assign w_in_take  = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_take) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_cipher <= i_cipher_word;
            r_s1_first  <= i_first_word;
            r_s1_last   <= i_last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_plain <= w_plain;
            r_out_crc   <= w_crc;
            r_out_match <= w_match;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_plain_word   = r_out_plain;
    assign o_running_crc  = r_out_crc;
    assign o_crc_match    = r_out_match;
    assign o_end_of_image = r_out_last;

endmodule

// ===== tb/tb_lcg_xor_decrypt_with_crc16_top.sv =====
// Self-checking testbench for lcg_xor_decrypt_with_crc16_top: feeds encrypted words,
// predicts plain word, running CRC and match flag, and checks every output transaction.
// Depends on lxdc_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_lcg_xor_decrypt_with_crc16_top;
    import lxdc_pkg::*;

    localparam logic [WORD_W-1:0] CRC_POLY_REFL = 16'hA001;
    localparam logic [WORD_W-1:0] CRC_START     = 16'hFFFF;

    typedef struct {
        logic [WORD_W-1:0] cipher;
        logic              first;
        logic              last;
    } t_cipher_item;

    typedef struct {
        logic [WORD_W-1:0] plain;
        logic [WORD_W-1:0] crc;
        logic              match;
        logic              eoi;
    } t_plain_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [WORD_W-1:0] i_cipher_word = '0;
    logic              i_first_word = 1'b0;
    logic              i_last_word = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [WORD_W-1:0] o_plain_word;
    logic [WORD_W-1:0] o_running_crc;
    logic              o_crc_match;
    logic              o_end_of_image;

    lcg_xor_decrypt_with_crc16_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cipher_word  (i_cipher_word),
        .i_first_word   (i_first_word),
        .i_last_word    (i_last_word),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_plain_word   (o_plain_word),
        .o_running_crc  (o_running_crc),
        .o_crc_match    (o_crc_match),
        .o_end_of_image (o_end_of_image)
    );

    // Register copies shared by the predictor and the stimulus planner.
    logic [WORD_W-1:0] cfg_seed = 16'd0;
    logic [WORD_W-1:0] cfg_mult = 16'd25173;
    logic [WORD_W-1:0] cfg_inc  = 16'd13849;
    logic [WORD_W-1:0] cfg_crc  = 16'd0;

    logic [WORD_W-1:0] key_now = '0;
    logic [WORD_W-1:0] crc_now = CRC_START;
    logic [WORD_W-1:0] plan_key = '0;
    logic [WORD_W-1:0] plan_crc = CRC_START;

    t_cipher_item  cipher_stream[$];
    t_plain_result expected_plain[$];
    t_cipher_item  on_offer;
    t_plain_result wanted;

    int   words_queued = 0;
    int   words_checked = 0;
    int   fail_count = 0;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   hold_left = 0;
    logic src_idle_on = 1'b0;
    logic sink_idle_on = 1'b0;
    logic hold_request = 1'b0;

    function automatic logic [WORD_W-1:0] lcg_advance(input logic [WORD_W-1:0] key,
                                                      input logic [WORD_W-1:0] mult,
                                                      input logic [WORD_W-1:0] inc);
        return key * mult + inc;
    endfunction

    function automatic logic [WORD_W-1:0] crc_fold(input logic [WORD_W-1:0] crc,
                                                   input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] c;
        c = crc ^ word;
        repeat (8) c = {1'b0, c[WORD_W-1:1]} ^ (c[0] ? CRC_POLY_REFL : '0);
        return c;
    endfunction

    function automatic t_plain_result decrypt_step(input t_cipher_item w);
        t_plain_result r;
        if (w.first) begin
            key_now = cfg_seed;
            crc_now = CRC_START;
        end
        key_now = lcg_advance(key_now, cfg_mult, cfg_inc);
        r.plain = w.cipher ^ key_now;
        crc_now = crc_fold(crc_now, r.plain);
        r.crc = crc_now;
        r.match = w.last && (crc_now == cfg_crc);
        r.eoi = w.last;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want_val,
                               input logic [WORD_W-1:0] got_val);
        if (want_val !== got_val) begin
            $error("%s: expected %h, actual %h", name, want_val, got_val);
            fail_count++;
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0] junk;
        junk = 16'($urandom);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {junk, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KEY_SEED:       cfg_seed = value;
            REG_KEY_MULTIPLIER: cfg_mult = value;
            REG_KEY_INCREMENT:  cfg_inc = value;
            REG_EXPECTED_CRC:   cfg_crc = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [WORD_W-1:0] seed, input logic [WORD_W-1:0] mult,
                             input logic [WORD_W-1:0] inc, input logic [WORD_W-1:0] crc);
        apb_write(REG_KEY_SEED, seed);
        apb_write(REG_KEY_MULTIPLIER, mult);
        apb_write(REG_KEY_INCREMENT, inc);
        apb_write(REG_EXPECTED_CRC, crc);
    endtask

    task automatic queue_word(input logic [WORD_W-1:0] cipher, input logic first,
                              input logic last);
        t_cipher_item w;
        w.cipher = cipher;
        w.first = first;
        w.last = last;
        if (first) begin
            plan_key = cfg_seed;
            plan_crc = CRC_START;
        end
        plan_key = lcg_advance(plan_key, cfg_mult, cfg_inc);
        plan_crc = crc_fold(plan_crc, cipher ^ plan_key);
        cipher_stream.push_back(w);
        words_queued++;
    endtask

    // The eight-step fold maps the low byte of its input onto a unique high byte,
    // so a search over 256 values finds the final word that lands on the expected CRC.
    task automatic queue_closing_word(input logic first);
        logic [WORD_W-1:0] key_nx;
        logic [WORD_W-1:0] crc_in;
        logic [WORD_W-1:0] g;
        logic [WORD_W-1:0] c;
        key_nx = lcg_advance(first ? cfg_seed : plan_key, cfg_mult, cfg_inc);
        crc_in = first ? CRC_START : plan_crc;
        c = '0;
        for (int b = 0; b < 256; b++) begin
            g = crc_fold('0, 16'(b));
            if (g[15:8] == cfg_crc[15:8])
                c = {cfg_crc[7:0] ^ g[7:0], 8'(b)};
        end
        queue_word(c ^ crc_in ^ key_nx, first, 1'b1);
    endtask

    task automatic queue_random_items(input int count);
        int stop_at;
        int len;
        int kind;
        stop_at = words_queued + count;
        while (words_queued < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                queue_word(16'($urandom), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end else if (kind == 1) begin
                len = $urandom_range(1, 5);
                for (int n = 0; n < len; n++)
                    queue_word(16'($urandom), n == 0, 1'b0);
            end else begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
                for (int n = 0; n < len - 1; n++)
                    queue_word(16'($urandom), n == 0, 1'b0);
                if ($urandom_range(0, 1))
                    queue_closing_word(len == 1);
                else
                    queue_word(16'($urandom), len == 1, 1'b1);
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (words_checked < words_queued);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_lcg_xor_decrypt_with_crc16_top: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_plain.push_back(decrypt_step(on_offer));
            if (!i_in_valid || o_in_ready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (src_idle_on && $urandom_range(0, 4) == 0) begin
                    src_gap <= $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (cipher_stream.size() != 0) begin
                    on_offer = cipher_stream.pop_front();
                    i_in_valid <= 1'b1;
                    i_cipher_word <= on_offer.cipher;
                    i_first_word <= on_offer.first;
                    i_last_word <= on_offer.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request)
            hold_left <= 80;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_plain.size() == 0) begin
                    $error("unexpected transaction: plain_word %h, running_crc %h",
                           o_plain_word, o_running_crc);
                    fail_count++;
                end else begin
                    wanted = expected_plain.pop_front();
                    words_checked++;
                    check_field("plain_word", wanted.plain, o_plain_word);
                    check_field("running_crc", wanted.crc, o_running_crc);
                    check_field("crc_match", 16'(wanted.match), 16'(o_crc_match));
                    check_field("end_of_image", 16'(wanted.eoi), 16'(o_end_of_image));
                end
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                i_out_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                sink_gap <= $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed words under the reset configuration.
        queue_word(16'h0000, 1'b0, 1'b0);
        queue_word(16'hFFFF, 1'b0, 1'b1);
        queue_word(16'h8001, 1'b0, 1'b0);
        queue_word(16'h5A5A, 1'b1, 1'b1);
        queue_closing_word(1'b1);
        queue_word(16'hFFFF, 1'b1, 1'b0);
        queue_word(16'h0000, 1'b0, 1'b0);
        queue_word(16'h7FFE, 1'b0, 1'b0);
        queue_closing_word(1'b0);
        queue_word(16'h1234, 1'b0, 1'b1);
        queue_closing_word(1'b0);
        queue_word(16'hA5C3, 1'b1, 1'b0);
        queue_word(16'h3C5A, 1'b0, 1'b1);
        wait_idle();

        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        src_idle_on <= 1'b1;
        sink_idle_on <= 1'b1;
        queue_word(16'hFFFF, 1'b1, 1'b1);
        queue_closing_word(1'b1);
        queue_random_items(300);
        wait_idle();

        configure(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        sink_idle_on <= 1'b0;
        queue_word(16'h0000, 1'b1, 1'b1);
        queue_closing_word(1'b1);
        queue_random_items(150);
        wait_idle();

        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        queue_random_items(400);
        @(posedge i_clk);
        hold_request <= 1'b1;
        @(posedge i_clk);
        hold_request <= 1'b0;
        wait_idle();

        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        src_idle_on <= 1'b0;
        sink_idle_on <= 1'b1;
        queue_random_items(350);
        wait_idle();

        // Final stretch runs at full rate in both directions.
        configure(16'($urandom), 16'($urandom) | 16'h0001, 16'($urandom), 16'($urandom));
        sink_idle_on <= 1'b0;
        queue_random_items(400);
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb_lcg_xor_decrypt_with_crc16_top: PASS");
        else
            $display("tb_lcg_xor_decrypt_with_crc16_top: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lxdc_pkg.sv
rtl/lxdc_regs.sv
rtl/lxdc_core.sv
rtl/lcg_xor_decrypt_with_crc16_top.sv
tb/tb_lcg_xor_decrypt_with_crc16_top.sv
